>>> src/gsmd_pkg.sv
// ----------------------------------------------------------------------------
// gsmd_pkg: shared types and constants for the gyro step and motion detector
// Sample and result transaction layouts, register indexes, reset values,
// classification limits and activity codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gsmd_pkg;

  // Register file layout
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_Y    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD_Z    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SAMPLES = 2'd2;

  // Reset values: 100 deg/s at 16.4 LSB per deg/s, 4000-sample window
  localparam logic signed [15:0] THRESHOLD_RST = 16'sd1640;
  localparam logic [15:0]        WINDOW_RST    = 16'd4000;

  // Classification limits on step growth per window
  localparam logic [31:0] STOP_MAX  = 32'd3;
  localparam logic [31:0] WALK_STEP = 32'd4;

  // Activity codes
  localparam logic [1:0] ACT_STOP = 2'd0;
  localparam logic [1:0] ACT_WALK = 2'd1;
  localparam logic [1:0] ACT_RUN  = 2'd2;

  // Input sample
  typedef struct packed {
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } gsmd_in_t;

  // Result
  typedef struct packed {
    logic [31:0] step_total;
    logic [1:0]  activity;
    logic        window_end;
  } gsmd_out_t;

endpackage

`default_nettype wire

>>> src/gyro_step_and_motion_detector_top.sv
// ----------------------------------------------------------------------------
// gyro_step_and_motion_detector_top: gyro threshold-crossing step counter
// Counts rising threshold crossings on the Y and Z rate axes, reports half
// their sum as the step total and classifies each window as stop/walk/run.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one Y/Z raw rate sample per transaction (valid/ready).
//   out_* : one result per sample, in order: step total, activity code and
//           a flag marking the sample that closed a classification window.
//   cfg_* : write-only register port (threshold_y, threshold_z,
//           window_samples); write only while the block is idle.
// Timing:
//   A sample is captured in an input register, then the edge detectors,
//   counters and window classifier update in one pass into the result
//   register, which drives out_valid. Throughput is one sample per cycle
//   while out_ready is high, set by that single update pass.
// Reset (rst_n low, synchronous): counters, armed flags and activity clear,
//   registers return to 1640 / 1640 / 4000, both pipeline slots empty.
// Stall: while out_ready is low the result holds; one more sample can wait
//   in the input register, after which in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gyro_step_and_motion_detector_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Sample channel
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire gsmd_pkg::gsmd_in_t                  in_data,
  // Result channel
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      gsmd_pkg::gsmd_out_t                 out_data,
  // Configuration
  input  wire logic                                cfg_we,
  input  wire logic [gsmd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [gsmd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gsmd_pkg::*;

  // Configuration registers
  logic signed [15:0] threshold_y_r;
  logic signed [15:0] threshold_z_r;
  logic [15:0]        window_samples_r;

  // Pipeline slots
  logic      in_valid_r;
  gsmd_in_t  in_data_r;
  logic      out_valid_r;
  gsmd_out_t out_data_r;

  // Detector state
  logic        armed_y_r, armed_z_r;
  logic [31:0] steps_y_r, steps_z_r;
  logic [15:0] window_count_r;
  logic [31:0] steps_start_r;
  logic [1:0]  motion_state_r;

  // Next values
  logic        armed_y_nxt, armed_z_nxt;
  logic [31:0] steps_y_nxt, steps_z_nxt;
  logic [15:0] window_count_nxt;
  logic [15:0] count_inc;
  logic [32:0] step_sum;
  logic [31:0] total;
  logic [31:0] grow;
  logic [1:0]  motion_state_nxt;
  logic        win_end;
  logic        advance;

  // Handshake: result slot frees when empty or taken
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_y_r    <= THRESHOLD_RST;
      threshold_z_r    <= THRESHOLD_RST;
      window_samples_r <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_THRESHOLD_Y:    threshold_y_r    <= $signed(cfg_wdata);
        REG_THRESHOLD_Z:    threshold_z_r    <= $signed(cfg_wdata);
        REG_WINDOW_SAMPLES: window_samples_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Edge detectors, counters and window classifier
  always_comb begin
    armed_y_nxt = armed_y_r;
    steps_y_nxt = steps_y_r;
    if (in_data_r.rate_y >= threshold_y_r) begin
      if (!armed_y_r) begin
        steps_y_nxt = steps_y_r + 32'd1;
        armed_y_nxt = 1'b1;
      end
    end else begin
      armed_y_nxt = 1'b0;
    end

    armed_z_nxt = armed_z_r;
    steps_z_nxt = steps_z_r;
    if (in_data_r.rate_z >= threshold_z_r) begin
      if (!armed_z_r) begin
        steps_z_nxt = steps_z_r + 32'd1;
        armed_z_nxt = 1'b1;
      end
    end else begin
      armed_z_nxt = 1'b0;
    end

    step_sum = {1'b0, steps_y_nxt} + {1'b0, steps_z_nxt};
    total    = step_sum[32:1];
    grow     = total - steps_start_r;

    count_inc        = window_count_r + 16'd1;
    win_end          = (count_inc >= window_samples_r);
    window_count_nxt = win_end ? 16'd0 : count_inc;

    motion_state_nxt = motion_state_r;
    if (win_end) begin
      if (grow <= STOP_MAX) begin
        motion_state_nxt = ACT_STOP;
      end else if (grow == WALK_STEP) begin
        motion_state_nxt = ACT_WALK;
      end else begin
        motion_state_nxt = ACT_RUN;
      end
    end
  end

  // Advance the pipeline and commit detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      armed_y_r      <= 1'b0;
      armed_z_r      <= 1'b0;
      steps_y_r      <= '0;
      steps_z_r      <= '0;
      window_count_r <= '0;
      steps_start_r  <= '0;
      motion_state_r <= ACT_STOP;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          armed_y_r      <= armed_y_nxt;
          armed_z_r      <= armed_z_nxt;
          steps_y_r      <= steps_y_nxt;
          steps_z_r      <= steps_z_nxt;
          window_count_r <= window_count_nxt;
          motion_state_r <= motion_state_nxt;
          if (win_end) begin
            steps_start_r <= total;
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (advance && in_valid_r) begin
      out_data_r.step_total <= total;
      out_data_r.activity   <= motion_state_nxt;
      out_data_r.window_end <= win_end;
    end
  end

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for gyro_step_and_motion_detector_top
// Drives Y/Z rate samples over valid/ready with random sender and receiver
// stalls, predicts every result from a local model of the crossing counters
// and window classifier, and compares each result transaction field by field.
// Directed tests cover thresholds, window extremes and the walk class; the
// random part runs gait-like oscillations and full-range noise under many
// register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gsmd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 390;  // per idling phase

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  gsmd_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  gsmd_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int fail_count        = 0;
  int cycle_count       = 0;

  gsmd_out_t expected_results[$];

  // Local copy of the detector registers and state
  logic signed [15:0] thr_y      = THRESHOLD_RST;
  logic signed [15:0] thr_z      = THRESHOLD_RST;
  logic [15:0]        win_len    = WINDOW_RST;
  logic               armed_y    = 1'b0;
  logic               armed_z    = 1'b0;
  logic [31:0]        count_y    = '0;
  logic [31:0]        count_z    = '0;
  logic [15:0]        win_count  = '0;
  logic [31:0]        win_base   = '0;
  logic [1:0]         activity_q = ACT_STOP;

  gyro_step_and_motion_detector_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Advance the step counters and window classifier by one sample
  function automatic gsmd_out_t predict_step(input gsmd_in_t s);
    gsmd_out_t   r;
    logic [32:0] sum;
    logic [31:0] growth;
    if (s.rate_y >= thr_y) begin
      if (!armed_y) begin
        count_y = count_y + 32'd1;
        armed_y = 1'b1;
      end
    end else begin
      armed_y = 1'b0;
    end
    if (s.rate_z >= thr_z) begin
      if (!armed_z) begin
        count_z = count_z + 32'd1;
        armed_z = 1'b1;
      end
    end else begin
      armed_z = 1'b0;
    end
    sum = {1'b0, count_y} + {1'b0, count_z};
    r.step_total = sum[32:1];
    r.window_end = 1'b0;
    win_count = win_count + 16'd1;
    if (win_count >= win_len) begin
      growth = r.step_total - win_base;
      if (growth <= STOP_MAX)
        activity_q = ACT_STOP;
      else if (growth == WALK_STEP)
        activity_q = ACT_WALK;
      else
        activity_q = ACT_RUN;
      win_count = '0;
      win_base = r.step_total;
      r.window_end = 1'b1;
    end
    r.activity = activity_q;
    return r;
  endfunction

  // Send one sample transaction; valid stays up into the next one unless a gap is drawn
  task automatic send_sample(input logic signed [15:0] ry, input logic signed [15:0] rz);
    gsmd_in_t s;
    s.rate_y = ry;
    s.rate_z = rz;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_step(s));
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register and mirror it in the predictor
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_THRESHOLD_Y:    thr_y = val;
      REG_THRESHOLD_Z:    thr_z = val;
      REG_WINDOW_SAMPLES: win_len = val;
      default: ;
    endcase
  endtask

  // Pick a rate at/above or below a threshold, often close to it
  function automatic logic signed [15:0] pick_rate(input int thr, input bit above);
    int span;
    int offset;
    if (above || thr == -32768) begin
      span = 32767 - thr;
      offset = int'($urandom_range(span));
      if ($urandom_range(1)) offset = offset % 64;
      return 16'(thr + offset);
    end
    span = thr + 32767;
    offset = int'($urandom_range(span));
    if ($urandom_range(1)) offset = offset % 64;
    return 16'(thr - 1 - offset);
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2, 3:    return 16'($urandom);
      default: return 16'(int'($urandom_range(6000)) - 3000);
    endcase
  endfunction

  function automatic logic [15:0] pick_window();
    case ($urandom_range(11))
      0:       return 16'($urandom_range(1));
      1:       return 16'hffff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(24, 2));
    endcase
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    gsmd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result step_total=%0d activity=%0d window_end=%0b",
                 $time, out_data.step_total, out_data.activity, out_data.window_end);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.step_total !== want.step_total) begin
          $display("%0t: step_total expected %0d actual %0d",
                   $time, want.step_total, out_data.step_total);
          fail_count++;
        end
        if (out_data.activity !== want.activity) begin
          $display("%0t: activity expected %0d actual %0d",
                   $time, want.activity, out_data.activity);
          fail_count++;
        end
        if (out_data.window_end !== want.window_end) begin
          $display("%0t: window_end expected %0b actual %0b",
                   $time, want.window_end, out_data.window_end);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL gyro_step_and_motion_detector_top");
      $finish;
    end
  end

  // Reset thresholds and window: crossings right at the threshold and field extremes
  task automatic test_reset_defaults();
    send_sample(16'sd1639, 16'sd1639);
    send_sample(16'sd1640, 16'sd1640);
    send_sample(16'sd1639, 16'sd32767);
    send_sample(16'sd32767, -16'sd32768);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd0, 16'sd1640);
    wait_for_results();
  endtask

  // Lowest and highest thresholds with one-sample windows
  task automatic test_threshold_extremes();
    write_reg(REG_THRESHOLD_Y, 16'h8000);
    write_reg(REG_THRESHOLD_Z, 16'h7fff);
    write_reg(REG_WINDOW_SAMPLES, 16'd1);
    send_sample(-16'sd32768, 16'sd32767);
    send_sample(16'sd32767, 16'sd32766);
    send_sample(16'sd0, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    wait_for_results();
  endtask

  // A zero-length window closes on every sample
  task automatic test_window_zero();
    write_reg(REG_WINDOW_SAMPLES, 16'd0);
    send_sample(16'sd100, 16'sd32767);
    send_sample(-16'sd100, -16'sd1);
    send_sample(16'sd100, 16'sd32767);
    wait_for_results();
  endtask

  // Shrink the window below the running count: the next sample closes it
  task automatic test_window_shrink();
    write_reg(REG_WINDOW_SAMPLES, 16'hffff);
    repeat (5) send_sample(16'($urandom), 16'($urandom));
    wait_for_results();
    write_reg(REG_WINDOW_SAMPLES, 16'd2);
    send_sample(16'sd5, -16'sd5);
    wait_for_results();
  endtask

  // Four crossings on both axes in an eight-sample window classify as walk
  task automatic test_walk_window();
    write_reg(REG_THRESHOLD_Y, 16'd0);
    write_reg(REG_THRESHOLD_Z, 16'd0);
    write_reg(REG_WINDOW_SAMPLES, 16'd8);
    repeat (4) begin
      send_sample(-16'sd1000, -16'sd1000);
      send_sample(16'sd1000, 16'sd1000);
    end
    wait_for_results();
  endtask

  // Segments of gait-like oscillation or noise, each under a fresh setting
  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    int sent;
    int seg_len;
    bit noise;
    bit up_y;
    bit up_z;
    int run_y;
    int run_z;
    sender_idle_pct   = send_pct;
    receiver_idle_pct = recv_pct;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_for_results();
      write_reg(REG_THRESHOLD_Y, pick_threshold());
      write_reg(REG_THRESHOLD_Z, pick_threshold());
      if ($urandom_range(3) != 0) write_reg(REG_WINDOW_SAMPLES, pick_window());
      seg_len = $urandom_range(70, 30);
      noise   = ($urandom_range(4) == 0);
      up_y    = $urandom_range(1);
      up_z    = $urandom_range(1);
      run_y   = $urandom_range(4, 1);
      run_z   = $urandom_range(4, 1);
      repeat (seg_len) begin
        if (noise) begin
          send_sample(16'($urandom), 16'($urandom));
        end else begin
          send_sample(pick_rate(int'(thr_y), up_y), pick_rate(int'(thr_z), up_z));
          run_y--;
          run_z--;
          if (run_y == 0) begin
            up_y  = !up_y;
            run_y = $urandom_range(4, 1);
          end
          if (run_z == 0) begin
            up_z  = !up_z;
            run_z = $urandom_range(4, 1);
          end
        end
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct   = 21;
    receiver_idle_pct = 45;
    test_reset_defaults();
    test_threshold_extremes();
    test_window_zero();
    test_window_shrink();
    test_walk_window();
    test_random_traffic(21, 45);
    test_random_traffic(45, 21);
    test_random_traffic(0, 0);
    wait_for_results();
    if (fail_count == 0) begin
      $display("PASS gyro_step_and_motion_detector_top");
    end else begin
      $display("FAIL gyro_step_and_motion_detector_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
